// File: design/eatrm_pkg.sv
// Shared types, constants and rounding helper for the Euler-angle rotation block.
package eatrm_pkg;

  // Trig values are Q2.30: a quarter turn of phase is 2^30, and one is 2^30.
  localparam int TRIG_FRAC = 30;

  // Defaults for the top-level parameters.
  localparam int ANGLE_BITS_DEF      = 16;
  localparam int ENTRY_FRAC_BITS_DEF = 14;

  // Width of every angle and every matrix entry on the ports.
  localparam int FIELD_BITS = 16;

  // Pipeline depths of the sine unit and of the matrix product unit.
  localparam int SIN_STAGES  = 15;
  localparam int MAT_STAGES  = 6;
  localparam int NUM_ENTRIES = 9;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef logic signed [31:0]           trig_t;
  typedef logic [30:0]                  mag_t;
  typedef logic [62:0]                  wide_mag_t;
  typedef logic signed [FIELD_BITS-1:0] entry_t;

  // Round a non-negative product with 60 fraction bits to 30 fraction bits, half up.
  function automatic logic [31:0] round_q30(input wide_mag_t mag);
    wide_mag_t sum;
    sum = mag + (wide_mag_t'(1) << (TRIG_FRAC - 1));
    return sum[TRIG_FRAC +: 32];
  endfunction

endpackage

// File: design/eatrm_sine.sv
// Pipelined fixed-point sine unit: phase fold, odd polynomial in Horner form, clamp.
module eatrm_sine
  import eatrm_pkg::*;
(
  input  logic                  clk,
  input  logic [SIN_STAGES-1:0] adv,
  input  logic [31:0]           phase,
  output trig_t                 sine
);

  localparam int STEPS = 5;

  // Polynomial coefficients, highest order first.
  localparam mag_t COEF [STEPS+1] = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  localparam logic signed [32:0] QTR_S  = 33'sh0_4000_0000;
  localparam logic signed [32:0] HALF_S = 33'sh0_8000_0000;
  localparam logic [31:0]        ONE_Q  = 32'h4000_0000;

  // Stage numbers inside this unit.
  localparam int ST_MM   = 1;
  localparam int ST_S2   = 2;
  localparam int ST_MP   = 3 + 2 * STEPS;
  localparam int ST_LAST = ST_MP + 1;

  logic signed [32:0] t_raw;
  logic signed [32:0] t_fold;
  logic signed [32:0] t_abs;
  mag_t               m_fold;

  mag_t        m_r   [0:ST_MP-1];
  logic        neg_r [0:ST_LAST-1];
  logic [61:0] mm_r;
  mag_t        s2_r  [ST_S2:ST_MP-3];
  logic [31:0] s2_rnd;
  logic [61:0] prod_r [STEPS];
  mag_t        p_r    [STEPS];
  logic [61:0] mp_r;
  logic [31:0] r_rnd;
  logic [31:0] r_clamp;
  trig_t       sine_r;

  // Fold the phase into the range of minus to plus a quarter turn.
  always_comb begin
    t_raw = 33'($signed(phase));
    if (t_raw > QTR_S) begin
      t_fold = HALF_S - t_raw;
    end else if (t_raw < -QTR_S) begin
      t_fold = -HALF_S - t_raw;
    end else begin
      t_fold = t_raw;
    end
    t_abs  = t_fold[32] ? -t_fold : t_fold;
    m_fold = t_abs[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m_r[0]   <= m_fold;
      neg_r[0] <= t_fold[32];
    end
  end

  // Magnitude and sign travel along with the polynomial.
  for (genvar k = 1; k < ST_MP; k++) begin : g_m_line
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        m_r[k] <= m_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < ST_LAST; k++) begin : g_neg_line
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // Square of the folded phase, then its rounding.
  always_ff @(posedge clk) begin
    if (adv[ST_MM]) begin
      mm_r <= 62'(m_r[0]) * 62'(m_r[0]);
    end
  end

  assign s2_rnd = round_q30(63'(mm_r));

  always_ff @(posedge clk) begin
    if (adv[ST_S2]) begin
      s2_r[ST_S2] <= s2_rnd[30:0];
    end
  end

  for (genvar k = ST_S2 + 1; k <= ST_MP - 3; k++) begin : g_s2_line
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        s2_r[k] <= s2_r[k-1];
      end
    end
  end

  // Each Horner step is one multiply stage and one round-and-subtract stage.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int SM = 3 + 2 * j;
    mag_t        p_in;
    logic [31:0] p_rnd;

    if (j == 0) begin : g_first
      assign p_in = COEF[0];
    end else begin : g_next
      assign p_in = p_r[j-1];
    end

    assign p_rnd = round_q30(63'(prod_r[j]));

    always_ff @(posedge clk) begin
      if (adv[SM]) begin
        prod_r[j] <= 62'(s2_r[SM-1]) * 62'(p_in);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[SM+1]) begin
        p_r[j] <= COEF[j+1] - p_rnd[30:0];
      end
    end
  end

  // Final multiply by the magnitude, clamp to one and restore the sign.
  always_ff @(posedge clk) begin
    if (adv[ST_MP]) begin
      mp_r <= 62'(m_r[ST_MP-1]) * 62'(p_r[STEPS-1]);
    end
  end

  assign r_rnd   = round_q30(63'(mp_r));
  assign r_clamp = (r_rnd > ONE_Q) ? ONE_Q : r_rnd;

  always_ff @(posedge clk) begin
    if (adv[ST_LAST]) begin
      sine_r <= neg_r[ST_LAST-1] ? -trig_t'(r_clamp) : trig_t'(r_clamp);
    end
  end

  assign sine = sine_r;

endmodule

// File: design/eatrm_matrix.sv
// Pipelined product, sum and output rounding stages that form the nine matrix entries.
module eatrm_matrix
  import eatrm_pkg::*;
#(
  parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
)(
  input  logic                  clk,
  input  logic [MAT_STAGES-1:0] adv,
  input  trig_t                 sx,
  input  trig_t                 cx,
  input  trig_t                 sy,
  input  trig_t                 cy,
  input  trig_t                 sz,
  input  trig_t                 cz,
  output entry_t                entry [NUM_ENTRIES]
);

  typedef logic signed [63:0] prod_t;
  typedef logic signed [33:0] sum_t;

  // Two-factor products of the first multiply stage.
  localparam int P_CZCY = 0;
  localparam int P_SZCY = 1;
  localparam int P_CZSY = 2;
  localparam int P_SZSY = 3;
  localparam int P_CZCX = 4;
  localparam int P_SZCX = 5;
  localparam int P_CYSX = 6;
  localparam int P_SZSX = 7;
  localparam int P_CZSX = 8;
  localparam int P_CYCX = 9;
  localparam int NP1    = 10;

  // Three-factor products of the second multiply stage.
  localparam int T_CZSYSX = 0;
  localparam int T_SZSYSX = 1;
  localparam int T_CZSYCX = 2;
  localparam int T_SZSYCX = 3;
  localparam int NP2      = 4;

  localparam int          RSH  = TRIG_FRAC - ENTRY_FRAC_BITS;
  localparam logic [33:0] HALF = (34'd1 << RSH) >> 1;
  localparam logic [33:0] LIM  = 34'd1 << ENTRY_FRAC_BITS;

  // Signed Q2.30 product rounding, half away from zero.
  function automatic trig_t qround(input prod_t v);
    prod_t       mag;
    logic [31:0] r;
    mag = v[63] ? -v : v;
    r   = round_q30(mag[62:0]);
    return v[63] ? -trig_t'(r) : trig_t'(r);
  endfunction

  // Round to the entry format, half away from zero, and saturate to plus or minus one.
  function automatic entry_t to_entry(input sum_t v);
    logic [33:0] mag;
    logic [33:0] rnd;
    logic [33:0] sat;
    logic [33:0] res;
    mag = v[33] ? 34'(-v) : 34'(v);
    rnd = (mag + HALF) >> RSH;
    sat = (rnd > LIM) ? LIM : rnd;
    res = v[33] ? -sat : sat;
    return entry_t'(res[FIELD_BITS-1:0]);
  endfunction

  trig_t  fa [NP1];
  trig_t  fb [NP1];
  prod_t  prod1_r [NP1];
  trig_t  q1_r    [NP1];
  trig_t  q1b_r   [NP1];
  trig_t  q1c_r   [NP1];
  prod_t  prod2_r [NP2];
  trig_t  q2_r    [NP2];
  trig_t  sx0_r, cx0_r, sx1_r, cx1_r;
  trig_t  sy0_r, sy1_r, sy2_r, sy3_r;
  sum_t   sum_r   [NUM_ENTRIES];
  entry_t entry_r [NUM_ENTRIES];

  // Operand pairs of the first multiply stage.
  assign fa[P_CZCY] = cz;  assign fb[P_CZCY] = cy;
  assign fa[P_SZCY] = sz;  assign fb[P_SZCY] = cy;
  assign fa[P_CZSY] = cz;  assign fb[P_CZSY] = sy;
  assign fa[P_SZSY] = sz;  assign fb[P_SZSY] = sy;
  assign fa[P_CZCX] = cz;  assign fb[P_CZCX] = cx;
  assign fa[P_SZCX] = sz;  assign fb[P_SZCX] = cx;
  assign fa[P_CYSX] = cy;  assign fb[P_CYSX] = sx;
  assign fa[P_SZSX] = sz;  assign fb[P_SZSX] = sx;
  assign fa[P_CZSX] = cz;  assign fb[P_CZSX] = sx;
  assign fa[P_CYCX] = cy;  assign fb[P_CYCX] = cx;

  // First multiply stage.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < NP1; i++) begin
        prod1_r[i] <= prod_t'(fa[i]) * prod_t'(fb[i]);
      end
      sx0_r <= sx;
      cx0_r <= cx;
      sy0_r <= sy;
    end
  end

  // Rounding of the first products.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < NP1; i++) begin
        q1_r[i] <= qround(prod1_r[i]);
      end
      sx1_r <= sx0_r;
      cx1_r <= cx0_r;
      sy1_r <= sy0_r;
    end
  end

  // Second multiply stage for the three-factor terms.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod2_r[T_CZSYSX] <= prod_t'(q1_r[P_CZSY]) * prod_t'(sx1_r);
      prod2_r[T_SZSYSX] <= prod_t'(q1_r[P_SZSY]) * prod_t'(sx1_r);
      prod2_r[T_CZSYCX] <= prod_t'(q1_r[P_CZSY]) * prod_t'(cx1_r);
      prod2_r[T_SZSYCX] <= prod_t'(q1_r[P_SZSY]) * prod_t'(cx1_r);
      q1b_r <= q1_r;
      sy2_r <= sy1_r;
    end
  end

  // Rounding of the three-factor terms.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < NP2; i++) begin
        q2_r[i] <= qround(prod2_r[i]);
      end
      q1c_r <= q1b_r;
      sy3_r <= sy2_r;
    end
  end

  // Exact sums of the entries.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sum_r[0] <= sum_t'(q1c_r[P_CZCY]);
      sum_r[1] <= sum_t'(q1c_r[P_SZCY]);
      sum_r[2] <= -sum_t'(sy3_r);
      sum_r[3] <= sum_t'(q2_r[T_CZSYSX]) - sum_t'(q1c_r[P_SZCX]);
      sum_r[4] <= sum_t'(q2_r[T_SZSYSX]) + sum_t'(q1c_r[P_CZCX]);
      sum_r[5] <= sum_t'(q1c_r[P_CYSX]);
      sum_r[6] <= sum_t'(q2_r[T_CZSYCX]) + sum_t'(q1c_r[P_SZSX]);
      sum_r[7] <= sum_t'(q2_r[T_SZSYCX]) - sum_t'(q1c_r[P_CZSX]);
      sum_r[8] <= sum_t'(q1c_r[P_CYCX]);
    end
  end

  // Output register with final rounding and saturation.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry_r[i] <= to_entry(sum_r[i]);
      end
    end
  end

  assign entry = entry_r;

endmodule

// File: design/euler_angles_to_rotation_matrix_top.sv
// Top level of the Euler-angle to rotation matrix block: angle stage, pipeline control, units.
// The block takes three binary angles (a full signed range is minus pi to pi) and returns the
// nine Q2.14 entries of the rotation, the transpose of the usual ZYX matrix of the negated
// angles, saturated to plus or minus one. It accepts one request every cycle while the output
// side does not stall; the pipeline depth comes from the sine polynomial, a chain of seven
// dependent multiplies that each get a multiply stage and a rounding stage, followed by two
// product levels, the entry sums and the output rounding. Every stage holds its own valid bit,
// so a stall at the output fills empty stages before ready drops.
module euler_angles_to_rotation_matrix_top
  import eatrm_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
)(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_BITS-1:0] in_angle_x,
  input  logic signed [FIELD_BITS-1:0] in_angle_y,
  input  logic signed [FIELD_BITS-1:0] in_angle_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_BITS-1:0] out_r00,
  output logic signed [FIELD_BITS-1:0] out_r01,
  output logic signed [FIELD_BITS-1:0] out_r02,
  output logic signed [FIELD_BITS-1:0] out_r10,
  output logic signed [FIELD_BITS-1:0] out_r11,
  output logic signed [FIELD_BITS-1:0] out_r12,
  output logic signed [FIELD_BITS-1:0] out_r20,
  output logic signed [FIELD_BITS-1:0] out_r21,
  output logic signed [FIELD_BITS-1:0] out_r22
);

  localparam int STAGES    = 1 + SIN_STAGES + MAT_STAGES;
  localparam int NUM_TRIG  = 6;
  localparam int ENTRY_LIM = 1 << ENTRY_FRAC_BITS;

  // Slots of the six sine units.
  localparam int T_SX = 0;
  localparam int T_CX = 1;
  localparam int T_SY = 2;
  localparam int T_CY = 3;
  localparam int T_SZ = 4;
  localparam int T_CZ = 5;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] adv;
  logic [31:0]       phase_nxt [NUM_TRIG];
  logic [31:0]       phase_r   [NUM_TRIG];
  trig_t             trig      [NUM_TRIG];
  entry_t            entry     [NUM_ENTRIES];

  // Reduce the angle to ANGLE_BITS, negate it and place it in a 32-bit phase.
  function automatic logic [31:0] neg_phase(input logic signed [FIELD_BITS-1:0] a);
    logic [ANGLE_BITS-1:0] v;
    v = ANGLE_BITS'(a);
    v = -v;
    return 32'(v) << (32 - ANGLE_BITS);
  endfunction

  // A stage moves when it is empty or every stage after it up to the output can move.
  for (genvar i = 0; i < STAGES; i++) begin : g_adv
    assign adv[i] = out_ready || !(&valid_r[STAGES-1:i]);
  end

  always_comb begin
    valid_nxt[0] = adv[0] ? in_valid : valid_r[0];
    for (int i = 1; i < STAGES; i++) begin
      valid_nxt[i] = adv[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = adv[0] && rst_n;
  assign out_valid = valid_r[STAGES-1];

  // Angle stage: sine phases and cosine phases, a quarter turn ahead.
  always_comb begin
    phase_nxt[T_SX] = neg_phase(in_angle_x);
    phase_nxt[T_CX] = neg_phase(in_angle_x) + QUARTER_TURN;
    phase_nxt[T_SY] = neg_phase(in_angle_y);
    phase_nxt[T_CY] = neg_phase(in_angle_y) + QUARTER_TURN;
    phase_nxt[T_SZ] = neg_phase(in_angle_z);
    phase_nxt[T_CZ] = neg_phase(in_angle_z) + QUARTER_TURN;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      phase_r <= phase_nxt;
    end
  end

  // Six sine units in lockstep.
  for (genvar k = 0; k < NUM_TRIG; k++) begin : g_trig
    eatrm_sine u_sine (
      .clk   (clk),
      .adv   (adv[SIN_STAGES:1]),
      .phase (phase_r[k]),
      .sine  (trig[k])
    );
  end

  eatrm_matrix #(
    .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
  ) u_matrix (
    .clk   (clk),
    .adv   (adv[STAGES-1:SIN_STAGES+1]),
    .sx    (trig[T_SX]),
    .cx    (trig[T_CX]),
    .sy    (trig[T_SY]),
    .cy    (trig[T_CY]),
    .sz    (trig[T_SZ]),
    .cz    (trig[T_CZ]),
    .entry (entry)
  );

  assign out_r00 = entry[0];
  assign out_r01 = entry[1];
  assign out_r02 = entry[2];
  assign out_r10 = entry[3];
  assign out_r11 = entry[4];
  assign out_r12 = entry[5];
  assign out_r20 = entry[6];
  assign out_r21 = entry[7];
  assign out_r22 = entry[8];

  // Ready only drops when every stage holds a request.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &valid_r)
    else $error("input blocked while a pipeline stage is empty");

  // A request taken without a result leaving adds exactly one to the occupancy.
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("accepted request lost or duplicated in the pipeline");

  // A result leaving without a new request removes exactly one.
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> ($countones(valid_r) == $past($countones(valid_r)) - 1))
    else $error("delivered result not removed from the pipeline");

  // Diagonal entries stay within plus or minus one when the format fits the field.
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((ENTRY_FRAC_BITS > FIELD_BITS - 2) ||
                   (int'(out_r00) <= ENTRY_LIM && int'(out_r00) >= -ENTRY_LIM &&
                    int'(out_r11) <= ENTRY_LIM && int'(out_r11) >= -ENTRY_LIM &&
                    int'(out_r22) <= ENTRY_LIM && int'(out_r22) >= -ENTRY_LIM)))
    else $error("diagonal entry outside saturation range");

endmodule
